>>> rtl/mcpu_pkg.sv
// Package for the microscopy contrast pixel unit: mode codes, path selects,
// configuration indexes, reset values and the pipeline enable struct.
// No dependencies.
package mcpu_pkg;

	typedef enum logic [2:0] {
		MODE_BF  = 3'd0,
		MODE_DF  = 3'd1,
		MODE_QDF = 3'd2,
		MODE_LR  = 3'd3,
		MODE_RL  = 3'd4,
		MODE_TB  = 3'd5,
		MODE_BT  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		SEL_SCALE = 2'd0,
		SEL_QDF   = 2'd1,
		SEL_RATIO = 2'd2,
		SEL_ZERO  = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_GAIN = 2'd1
	} cfg_idx_t;

	localparam int          CFG_IDX_W    = 2;
	localparam int          CFG_DATA_W   = 16;
	localparam logic [2:0]  MODE_RST     = 3'd0;
	localparam logic [15:0] QDF_GAIN_RST = 16'd3686;
	localparam logic [5:0]  DARK_PAIR    = 6'd31;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

>>> rtl/mcpu_if.sv
// Handshake interfaces of the contrast pixel unit: pixel words in, result
// words out, configuration writes. Depends on mcpu_pkg.
interface mcpu_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pix_a;
	logic [7:0] pix_b;
	logic [7:0] pix_c;
	logic [7:0] pix_d;
	modport source(output valid, output pix_a, output pix_b, output pix_c, output pix_d,
		input ready);
	modport sink(input valid, input pix_a, input pix_b, input pix_c, input pix_d,
		output ready);
endinterface

interface mcpu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_pixel;
	modport source(output valid, output out_pixel, input ready);
	modport sink(input valid, input out_pixel, output ready);
endinterface

interface mcpu_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mcpu_pkg::CFG_IDX_W-1:0]  index;
	logic [mcpu_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/mcpu_ratio_div.sv
// Three-stage restoring divider for floor(num/den), two quotient bits per stage.
// Depends on mcpu_pkg (pipe_en_t).
module mcpu_ratio_div import mcpu_pkg::*; (
	input  logic       clk,
	input  pipe_en_t   en,
	input  logic [13:0] num,
	input  logic [8:0]  den,
	output logic [5:0]  quo
);

	logic [13:0] rem_s2, rem_s3;
	logic [8:0]  den_s2, den_s3;
	logic [1:0]  q_s2;
	logic [3:0]  q_s3;
	logic [5:0]  q_s4;

	logic [13:0] ra, rb, rc, rd, re, rf;
	logic        b5, b4, b3, b2, b1, b0;

	function automatic logic [14:0] div_step(input logic [13:0] r, input logic [8:0] d,
		input int k);
		logic [13:0] t;
		t = {5'd0, d} << k;
		if (r >= t)
			div_step = {1'b1, r - t};
		else
			div_step = {1'b0, r};
	endfunction

	always_comb begin
		{b5, ra} = div_step(num, den, 5);
		{b4, rb} = div_step(ra, den, 4);
		{b3, rc} = div_step(rem_s2, den_s2, 3);
		{b2, rd} = div_step(rc, den_s2, 2);
		{b1, re} = div_step(rem_s3, den_s3, 1);
		{b0, rf} = div_step(re, den_s3, 0);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			rem_s2 <= rb;
			den_s2 <= den;
			q_s2   <= {b5, b4};
		end
		if (en.s3) begin
			rem_s3 <= rd;
			den_s3 <= den_s2;
			q_s3   <= {q_s2, b3, b2};
		end
		if (en.s4) begin
			q_s4 <= {q_s3, b1, b0};
		end
	end

	assign quo = q_s4;

endmodule

>>> rtl/microscopy_contrast_pixel_unit_core.sv
// Contrast pixel unit: five-stage pipeline from four frame pixels to one contrast pixel.
// Depends on mcpu_pkg, mcpu_if and mcpu_ratio_div.
//
// Channels: pix carries one word of four co-located pixels (pix_a..pix_d),
// res carries one out_pixel word per input word, cfg writes the mode (index 0)
// and the qdf gain (index 1, unsigned Q4.12); other indexes are dropped.
// cfg is always ready; the user must write cfg only while the pipeline is empty,
// as the block itself does not enforce this.
// Throughput: one word per cycle in every mode while res is ready; the
// ratio divider is split into three stages of two quotient bits each and the
// qdf path uses one 16x10 multiplier, so no unit is shared between words.
// Stall: each stage holds its word while the next one is full and held; bubbles
// collapse, so pix stays ready while any stage is empty, even with a result
// waiting on res.
// Reset: arst_n empties the pipeline and sets mode to brightfield and the
// gain to 3686 (about 0.9).
module microscopy_contrast_pixel_unit_core import mcpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mcpu_pix_if.sink    pix,
	mcpu_out_if.source  res,
	mcpu_cfg_if.sink    cfg
);

	localparam logic [19:0] SAT_LIMIT = 20'd65280;

	logic [2:0]  mode_q;
	logic [15:0] gain_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic en1;
	pipe_en_t en;

	// stage 1
	sel_t        sel_c, sel_s1;
	logic        swap_c;
	logic [7:0]  ad1, ad2, nsel;
	logic [13:0] a63_c, a63_s1;
	logic [9:0]  sum_c, sum_s1;
	logic [8:0]  edg_c, edg_s1;
	logic [13:0] num_c, num_s1;
	logic [8:0]  den_c, den_s1;
	logic [15:0] gain_s1;

	// stage 2
	sel_t        sel_s2;
	logic [13:0] a63_s2;
	logic [25:0] prod_c;
	logic [26:0] val_c, val_s2;
	logic        dark_s1, dark_s2, dark_s3, dark_s4;

	// stage 3
	sel_t        sel_s3;
	logic [13:0] a63_s3;
	logic        pos_c, pos_s3, pos_s4;
	logic [31:0] n63_c;
	logic [19:0] y_c;
	logic        sat_s3, sat_s4;
	logic [15:0] x_s3;

	// stage 4
	sel_t        sel_s4;
	logic [15:0] xsel_c, x_s4;
	logic [24:0] qm_c;
	logic [7:0]  qe_s4;
	logic [5:0]  quo;

	// stage 5
	logic [15:0] mul255_c, rem_c;
	logic [7:0]  qfix_c;
	logic [7:0]  out_c, out_s5;

	function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
		abs_diff = (x > y) ? (x - y) : (y - x);
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
			gain_q <= QDF_GAIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_MODE: mode_q <= cfg.data[2:0];
				CFG_GAIN: gain_q <= cfg.data;
				default:  ;
			endcase
		end
	end

	assign rdy5      = !v_s5 || res.ready;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign pix.ready = rdy1;

	assign en1   = rdy1 && pix.valid;
	assign en.s2 = rdy2 && v_s1;
	assign en.s3 = rdy3 && v_s2;
	assign en.s4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		swap_c = 1'b0;
		unique case (mode_q)
			MODE_BF, MODE_DF: sel_c = SEL_SCALE;
			MODE_QDF:         sel_c = SEL_QDF;
			MODE_LR, MODE_TB: sel_c = SEL_RATIO;
			MODE_RL, MODE_BT: begin
				sel_c  = SEL_RATIO;
				swap_c = 1'b1;
			end
			default:          sel_c = SEL_ZERO;
		endcase
	end

	always_comb begin
		a63_c = {pix.pix_a, 6'd0} - {6'd0, pix.pix_a};
		sum_c = {2'd0, pix.pix_a} + {2'd0, pix.pix_b} + {2'd0, pix.pix_c} + {2'd0, pix.pix_d};
		ad1   = abs_diff(pix.pix_a, pix.pix_c);
		ad2   = abs_diff(pix.pix_d, pix.pix_b);
		edg_c = {1'b0, ad1} + {1'b0, ad2};
		nsel  = swap_c ? pix.pix_b : pix.pix_a;
		num_c = {nsel, 6'd0} - {6'd0, nsel};
		den_c = {1'b0, pix.pix_a} + {1'b0, pix.pix_b};
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sel_s1  <= sel_c;
			a63_s1  <= a63_c;
			sum_s1  <= sum_c;
			edg_s1  <= edg_c;
			num_s1  <= num_c;
			den_s1  <= den_c;
			dark_s1 <= (den_c == 9'd0);
			gain_s1 <= gain_q;
		end
	end

	// gain*sum - 4096*edge, two's complement
	always_comb begin
		prod_c = {10'd0, gain_s1} * {16'd0, sum_s1};
		val_c  = {1'b0, prod_c} - {6'd0, edg_s1, 12'd0};
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sel_s2  <= sel_s1;
			a63_s2  <= a63_s1;
			val_s2  <= val_c;
			dark_s2 <= dark_s1;
		end
	end

	always_comb begin
		pos_c = !val_s2[26] && (val_s2 != 27'd0);
		n63_c = {val_s2[25:0], 6'd0} - {6'd0, val_s2[25:0]};
		y_c   = n63_c[31:12];
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sel_s3  <= sel_s2;
			a63_s3  <= a63_s2;
			pos_s3  <= pos_c;
			sat_s3  <= (y_c >= SAT_LIMIT);
			x_s3    <= y_c[15:0];
			dark_s3 <= dark_s2;
		end
	end

	// x/255 estimate: x*257 >> 16, low by at most one
	always_comb begin
		xsel_c = (sel_s3 == SEL_SCALE) ? {2'd0, a63_s3} : x_s3;
		qm_c   = {9'd0, xsel_c} + {1'b0, xsel_c, 8'd0};
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sel_s4  <= sel_s3;
			x_s4    <= xsel_c;
			qe_s4   <= qm_c[23:16];
			pos_s4  <= pos_s3;
			sat_s4  <= sat_s3;
			dark_s4 <= dark_s3;
		end
	end

	mcpu_ratio_div u_div (
		.clk (clk),
		.en  (en),
		.num (num_s1),
		.den (den_s1),
		.quo (quo)
	);

	always_comb begin
		mul255_c = {qe_s4, 8'd0} - {8'd0, qe_s4};
		rem_c    = x_s4 - mul255_c;
		qfix_c   = (rem_c >= 16'd255) ? (qe_s4 + 8'd1) : qe_s4;
		unique case (sel_s4)
			SEL_SCALE: out_c = qfix_c;
			SEL_QDF:   out_c = !pos_s4 ? 8'd0 : (sat_s4 ? 8'd255 : qfix_c);
			SEL_RATIO: out_c = dark_s4 ? {2'd0, DARK_PAIR} : {2'd0, quo};
			SEL_ZERO:  out_c = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4)
			out_s5 <= out_c;
	end

	assign res.valid     = v_s5;
	assign res.out_pixel = out_s5;

`ifndef SYNTH
	a_est_off_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && (sel_s4 == SEL_SCALE || (sel_s4 == SEL_QDF && pos_s4 && !sat_s4))
		|-> rem_c < 16'd510)
		else $error("x/255 estimate off by more than one");

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && sel_s4 == SEL_SCALE |-> qfix_c <= 8'd63)
		else $error("scaled pixel above 63");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> v_s1)
		else $error("accepted word not in stage 1");

	a_free_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid || res.ready |-> pix.ready)
		else $error("input stalled while output can drain");

	a_stall_holds_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && v_s5 && !res.ready |=> v_s4 && $stable(qe_s4) && $stable(x_s4))
		else $error("stage 4 word lost under stall");
`endif

endmodule
